// ===== rtl/wsid_pkg.sv =====
// Shared types, constants and prefix-code tables of the whitespace instruction decoder.
`timescale 1ns / 1ps

package wsid_pkg;

  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_LF    = 8'd10;

  typedef enum logic [1:0] {
    SYM_SPACE,
    SYM_TAB,
    SYM_LF,
    SYM_NONE
  } sym_t;

  // Decode stages are named by the prefix read so far; the last eight read a number.
  typedef enum logic [4:0] {
    ST_START,
    ST_IMP_TAB,
    ST_STACK,
    ST_STACK_TAB,
    ST_STACK_LF,
    ST_ARITH,
    ST_ARITH_SPACE,
    ST_ARITH_TAB,
    ST_HEAP,
    ST_FLOW,
    ST_FLOW_SPACE,
    ST_FLOW_TAB,
    ST_FLOW_LF,
    ST_IO,
    ST_IO_OUT,
    ST_IO_IN,
    ST_NUM_PUSH,
    ST_NUM_COPY,
    ST_NUM_SLIDE,
    ST_NUM_LABEL,
    ST_NUM_CALL,
    ST_NUM_JUMP,
    ST_NUM_JZ,
    ST_NUM_JN
  } stage_t;

  typedef enum logic [4:0] {
    OP_PUSH, OP_COPY, OP_SLIDE, OP_DUP, OP_SWAP, OP_DISCARD,
    OP_LABEL, OP_CALL, OP_JUMP, OP_JZ, OP_JN, OP_RET, OP_EXIT,
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_STORE, OP_RETRIEVE,
    OP_OUTCHAR, OP_OUTNUM, OP_READCHAR, OP_READNUM
  } op_t;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_UNDEFINED,
    ERR_MISSING_NUMBER,
    ERR_TOO_LONG,
    ERR_TOO_MANY
  } err_t;

  typedef enum logic [1:0] {
    PK_NEXT,
    PK_EMIT,
    PK_BAD
  } pkind_t;

  typedef struct packed {
    pkind_t kind;
    stage_t stage;
    op_t    op;
  } prefix_t;

  // Outcome of decoding one symbol, handed from the decoder to the result register.
  typedef struct packed {
    logic emit;
    op_t  op;
    err_t err;
  } result_ctrl_t;

  function automatic sym_t classify(input logic [7:0] c);
    sym_t s;
    case (c)
      CHAR_SPACE: s = SYM_SPACE;
      CHAR_TAB:   s = SYM_TAB;
      CHAR_LF:    s = SYM_LF;
      default:    s = SYM_NONE;
    endcase
    return s;
  endfunction

  function automatic prefix_t pk_go(input stage_t s);
    prefix_t p;
    p.kind  = PK_NEXT;
    p.stage = s;
    p.op    = OP_PUSH;
    return p;
  endfunction

  function automatic prefix_t pk_emit(input op_t o);
    prefix_t p;
    p.kind  = PK_EMIT;
    p.stage = ST_START;
    p.op    = o;
    return p;
  endfunction

  function automatic prefix_t pk_bad();
    prefix_t p;
    p.kind  = PK_BAD;
    p.stage = ST_START;
    p.op    = OP_PUSH;
    return p;
  endfunction

  function automatic prefix_t pick(input prefix_t a, input prefix_t b, input prefix_t c,
                                   input sym_t sym);
    prefix_t p;
    case (sym)
      SYM_SPACE: p = a;
      SYM_TAB:   p = b;
      default:   p = c;
    endcase
    return p;
  endfunction

  // One step of the instruction prefix tree; the number stages are handled elsewhere.
  function automatic prefix_t prefix_step(input stage_t stage, input sym_t sym);
    prefix_t p;
    case (stage)
      ST_START:       p = pick(pk_go(ST_STACK), pk_go(ST_IMP_TAB), pk_go(ST_FLOW), sym);
      ST_IMP_TAB:     p = pick(pk_go(ST_ARITH), pk_go(ST_HEAP), pk_go(ST_IO), sym);
      ST_STACK:       p = pick(pk_go(ST_NUM_PUSH), pk_go(ST_STACK_TAB),
                               pk_go(ST_STACK_LF), sym);
      ST_STACK_TAB:   p = pick(pk_go(ST_NUM_COPY), pk_bad(), pk_go(ST_NUM_SLIDE), sym);
      ST_STACK_LF:    p = pick(pk_emit(OP_DUP), pk_emit(OP_SWAP), pk_emit(OP_DISCARD), sym);
      ST_ARITH:       p = pick(pk_go(ST_ARITH_SPACE), pk_go(ST_ARITH_TAB), pk_bad(), sym);
      ST_ARITH_SPACE: p = pick(pk_emit(OP_ADD), pk_emit(OP_SUB), pk_emit(OP_MUL), sym);
      ST_ARITH_TAB:   p = pick(pk_emit(OP_DIV), pk_emit(OP_MOD), pk_bad(), sym);
      ST_HEAP:        p = pick(pk_emit(OP_STORE), pk_emit(OP_RETRIEVE), pk_bad(), sym);
      ST_FLOW:        p = pick(pk_go(ST_FLOW_SPACE), pk_go(ST_FLOW_TAB),
                               pk_go(ST_FLOW_LF), sym);
      ST_FLOW_SPACE:  p = pick(pk_go(ST_NUM_LABEL), pk_go(ST_NUM_CALL),
                               pk_go(ST_NUM_JUMP), sym);
      ST_FLOW_TAB:    p = pick(pk_go(ST_NUM_JZ), pk_go(ST_NUM_JN), pk_emit(OP_RET), sym);
      ST_FLOW_LF:     p = pick(pk_bad(), pk_bad(), pk_emit(OP_EXIT), sym);
      ST_IO:          p = pick(pk_go(ST_IO_OUT), pk_go(ST_IO_IN), pk_bad(), sym);
      ST_IO_OUT:      p = pick(pk_emit(OP_OUTCHAR), pk_emit(OP_OUTNUM), pk_bad(), sym);
      ST_IO_IN:       p = pick(pk_emit(OP_READCHAR), pk_emit(OP_READNUM), pk_bad(), sym);
      default:        p = pk_bad();
    endcase
    return p;
  endfunction

  function automatic op_t number_op(input logic [2:0] idx);
    op_t o;
    case (idx)
      3'd0:    o = OP_PUSH;
      3'd1:    o = OP_COPY;
      3'd2:    o = OP_SLIDE;
      3'd3:    o = OP_LABEL;
      3'd4:    o = OP_CALL;
      3'd5:    o = OP_JUMP;
      3'd6:    o = OP_JZ;
      default: o = OP_JN;
    endcase
    return o;
  endfunction

endpackage

// ===== rtl/wsid_decode.sv =====
// Next-state and result logic for one decoded symbol of the instruction stream.
`timescale 1ns / 1ps

module wsid_decode #(
  parameter int ARG_BITS   = 32,
  parameter int INDEX_BITS = 16
) (
  input  wsid_pkg::sym_t          sym,
  input  wsid_pkg::stage_t        stage,
  input  logic                    sign_seen,
  input  logic                    sign_neg,
  input  logic [ARG_BITS-1:0]     accum,
  input  logic                    have_digit,
  input  logic [INDEX_BITS-1:0]   counter,
  output wsid_pkg::stage_t        stage_next,
  output logic                    sign_seen_next,
  output logic                    sign_neg_next,
  output logic [ARG_BITS-1:0]     accum_next,
  output logic                    have_digit_next,
  output wsid_pkg::result_ctrl_t  ctrl,
  output logic signed [ARG_BITS:0] arg
);
  import wsid_pkg::*;

  prefix_t             pfx;
  logic                fin;
  op_t                 fin_op;
  logic [ARG_BITS:0]   fin_arg;
  logic [ARG_BITS:0]   mag;
  logic                is_signed;

  assign mag       = {1'b0, accum};
  assign is_signed = (stage <= ST_NUM_SLIDE);
  assign pfx       = prefix_step(stage, sym);

  always_comb begin
    stage_next      = stage;
    sign_seen_next  = sign_seen;
    sign_neg_next   = sign_neg;
    accum_next      = accum;
    have_digit_next = have_digit;
    fin             = 1'b0;
    fin_op          = OP_PUSH;
    fin_arg         = '0;
    ctrl.emit       = 1'b0;
    ctrl.op         = OP_PUSH;
    ctrl.err        = ERR_NONE;

    if (stage < ST_NUM_PUSH) begin
      case (pfx.kind)
        PK_BAD: begin
          ctrl.emit = 1'b1;
          ctrl.err  = ERR_UNDEFINED;
        end
        PK_EMIT: begin
          fin    = 1'b1;
          fin_op = pfx.op;
        end
        default: begin
          stage_next = pfx.stage;
          // Entering a number clears the sign and digit state.
          if (pfx.stage >= ST_NUM_PUSH) begin
            sign_seen_next  = 1'b0;
            sign_neg_next   = 1'b0;
            accum_next      = '0;
            have_digit_next = 1'b0;
          end
        end
      endcase
    end else if (stage > ST_NUM_JN) begin
      stage_next = ST_START;
    end else if (sym == SYM_LF) begin
      if (!have_digit) begin
        ctrl.emit = 1'b1;
        ctrl.err  = ERR_MISSING_NUMBER;
      end else begin
        fin     = 1'b1;
        fin_op  = number_op(stage[2:0]);
        fin_arg = (is_signed && sign_neg) ? (ARG_BITS+1)'(~mag + 1'b1) : mag;
      end
    end else if (is_signed && !sign_seen) begin
      sign_seen_next = 1'b1;
      sign_neg_next  = (sym == SYM_TAB);
    end else if (accum[ARG_BITS-1]) begin
      ctrl.emit = 1'b1;
      ctrl.err  = ERR_TOO_LONG;
    end else begin
      accum_next      = {accum[ARG_BITS-2:0], sym == SYM_TAB};
      have_digit_next = 1'b1;
    end

    if (fin) begin
      ctrl.emit = 1'b1;
      if (&counter) begin
        ctrl.err = ERR_TOO_MANY;
      end else begin
        ctrl.op    = fin_op;
        stage_next = ST_START;
      end
    end
  end

  assign arg = (fin && ctrl.err == ERR_NONE) ? $signed(fin_arg) : '0;

endmodule

// ===== rtl/whitespace_instruction_decoder.sv =====
// Top level of the whitespace instruction decoder: input register, decode state, result register.
`timescale 1ns / 1ps

// Takes one source byte per word on the char channel and delivers one decoded
// instruction per word on the res channel. Only space, tab and line feed matter;
// all other bytes are taken and dropped. The block sustains one byte per clock
// while the result register is not stalled: a byte is held in the input register,
// the prefix decoder and number accumulator update their state in a single pass,
// and the result lands in the output register, which holds it until it is taken.
// A stalled result register holds the decoder; the input register then fills and
// char_ready drops. Any error yields one result with opcode 0, argument 0 and a
// nonzero error_code, after which all input is swallowed until reset.
module whitespace_instruction_decoder #(
  parameter int ARG_BITS   = 32,
  parameter int INDEX_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     char_valid,
  output logic                     char_ready,
  input  logic [7:0]               char_code,
  output logic                     res_valid,
  input  logic                     res_ready,
  output logic [4:0]               opcode,
  output logic signed [ARG_BITS:0] argument,
  output logic [INDEX_BITS-1:0]    instr_index,
  output logic [2:0]               error_code
);
  import wsid_pkg::*;

  logic                   stg_valid;
  sym_t                   stg_sym;
  stage_t                 stage,  stage_next;
  logic                   sign_seen, sign_seen_next;
  logic                   sign_neg, sign_neg_next;
  logic [ARG_BITS-1:0]    accum, accum_next;
  logic                   have_digit, have_digit_next;
  logic [INDEX_BITS-1:0]  counter;
  logic                   halted;
  result_ctrl_t           ctrl;
  logic signed [ARG_BITS:0] arg;
  sym_t                   in_sym;
  logic                   fire;

  assign in_sym     = classify(char_code);
  assign fire       = stg_valid && !halted && (!res_valid || res_ready);
  assign char_ready = !stg_valid || halted || !res_valid || res_ready;

  wsid_decode #(
    .ARG_BITS   (ARG_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_decode (
    .sym             (stg_sym),
    .stage           (stage),
    .sign_seen       (sign_seen),
    .sign_neg        (sign_neg),
    .accum           (accum),
    .have_digit      (have_digit),
    .counter         (counter),
    .stage_next      (stage_next),
    .sign_seen_next  (sign_seen_next),
    .sign_neg_next   (sign_neg_next),
    .accum_next      (accum_next),
    .have_digit_next (have_digit_next),
    .ctrl            (ctrl),
    .arg             (arg)
  );

  // Input register: keeps only the three meaningful symbols.
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
      stg_sym   <= SYM_NONE;
    end else if (char_ready) begin
      stg_valid <= char_valid && (in_sym != SYM_NONE) && !halted;
      stg_sym   <= in_sym;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage      <= ST_START;
      sign_seen  <= 1'b0;
      sign_neg   <= 1'b0;
      accum      <= '0;
      have_digit <= 1'b0;
      counter    <= '0;
      halted     <= 1'b0;
    end else if (fire) begin
      stage      <= stage_next;
      sign_seen  <= sign_seen_next;
      sign_neg   <= sign_neg_next;
      accum      <= accum_next;
      have_digit <= have_digit_next;
      if (ctrl.emit && ctrl.err == ERR_NONE) begin
        counter <= counter + 1'b1;
      end
      if (ctrl.emit && ctrl.err != ERR_NONE) begin
        halted <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire && ctrl.emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && ctrl.emit) begin
      opcode      <= ctrl.op;
      argument    <= arg;
      instr_index <= counter;
      error_code  <= ctrl.err;
    end
  end

endmodule

// ===== rtl/wsid_checker.sv =====
// Port-level checks of the whitespace instruction decoder and their binding.
`timescale 1ns / 1ps

module wsid_checker #(
  parameter int ARG_BITS   = 32,
  parameter int INDEX_BITS = 16
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     res_valid,
  input logic                     res_ready,
  input logic [4:0]               opcode,
  input logic signed [ARG_BITS:0] argument,
  input logic [INDEX_BITS-1:0]    instr_index,
  input logic [2:0]               error_code
);
  import wsid_pkg::*;

  logic                  seen;
  logic [INDEX_BITS-1:0] last_idx;
  logic                  res_take;

  assign res_take = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen     <= 1'b0;
      last_idx <= '0;
    end else if (res_take) begin
      seen     <= 1'b1;
      last_idx <= instr_index;
    end
  end

  // Once an error word is taken the block stays silent.
  a_halt: assert property (@(posedge clk) disable iff (rst)
    res_take && error_code != ERR_NONE |=> !res_valid)
    else $error("result after an error word");

  a_err_payload: assert property (@(posedge clk) disable iff (rst)
    res_valid && error_code != ERR_NONE |-> opcode == OP_PUSH && argument == '0)
    else $error("error word carries opcode or argument");

  // Every delivered word, error or not, carries the next index.
  a_index_seq: assert property (@(posedge clk) disable iff (rst)
    res_take && seen |-> instr_index == INDEX_BITS'(last_idx + 1'b1))
    else $error("instruction index out of sequence");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(opcode) && $stable(argument)
      && $stable(instr_index) && $stable(error_code))
    else $error("stalled result word changed");

endmodule

bind whitespace_instruction_decoder wsid_checker #(
  .ARG_BITS   (ARG_BITS),
  .INDEX_BITS (INDEX_BITS)
) u_wsid_checker (.*);
